// ----- rtl/fmnb_pkg.sv -----
// ----------------------------------------------------------------------------
// fmnb_pkg
// shared widths, constants and the request type for frequency to midi note
// ----------------------------------------------------------------------------
package fmnb_pkg;

    localparam int FREQ_WIDTH_DEF = 24;
    localparam int RANGE_W        = 12;
    localparam int NOTE_W         = 7;
    localparam int BEND_W         = 14;
    localparam int LOG_FRAC       = 16;
    // log2(440 Hz * 256) in q.16, as the squaring loop produces it
    localparam logic [20:0] L440  = 21'd1099783;
    localparam logic [11:0] RANGE_RESET = 12'd100;
    localparam logic [13:0] BEND_CENTER = 14'd8192;
    localparam logic [13:0] BEND_MAX    = 14'd16383;
    localparam logic [6:0]  NOTE_MAX    = 7'd127;

    // request passed from the front to the back through the queue
    typedef struct packed {
        logic        zero;
        logic [20:0] lg;    // log2 q.16, integer part 5 bits
    } req_t;

endpackage

// ----- rtl/fmnb_front.sv -----
// ----------------------------------------------------------------------------
// fmnb_front
// accepts frequencies, finds the top bit and iterates log2 one bit a cycle
// ----------------------------------------------------------------------------
module fmnb_front #(
    parameter int FREQ_WIDTH = fmnb_pkg::FREQ_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FREQ_WIDTH-1:0] freq,
    output logic                  req_valid,
    input  logic                  req_ready,
    output fmnb_pkg::req_t        req
);
    localparam int EW = $clog2(FREQ_WIDTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ITER = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [31:0] m_reg, m_next;
    logic [15:0] frac_reg, frac_next;
    logic [4:0]  e_reg, e_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        zero_reg, zero_next;

    logic [EW-1:0]         top;
    logic [FREQ_WIDTH-1:0] norm;
    logic [63:0]           sq;
    logic [32:0]           sqs;

    always_comb
    begin
        top = '0;
        for (int i = 0; i < FREQ_WIDTH; i++)
        begin
            if (freq[i])
            begin
                top = EW'(i);
            end
        end
    end

    assign norm = freq << (EW'(FREQ_WIDTH - 1) - top);
    assign sq   = m_reg * m_reg;
    assign sqs  = sq[63:31];

    assign in_ready  = (state_reg == S_IDLE);
    assign req_valid = (state_reg == S_OUT);
    assign req.zero  = zero_reg;
    assign req.lg    = {e_reg, frac_reg};

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        e_next     = e_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    zero_next  = (freq == '0);
                    e_next     = 5'(top);
                    // mantissa q1.31 with the top set bit at bit 31
                    m_next     = 32'(norm) << (32 - FREQ_WIDTH);
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = S_ITER;
                end
            end
            S_ITER:
            begin
                // square, keep q1.31; renormalize when >= 2
                if (sqs[32])
                begin
                    m_next    = sqs[32:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next    = sqs[31:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (req_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        frac_reg <= frac_next;
        e_reg    <= e_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
    end

endmodule

// ----- rtl/fmnb_queue.sv -----
// ----------------------------------------------------------------------------
// fmnb_queue
// two-entry queue between the log2 front and the note back
// ----------------------------------------------------------------------------
module fmnb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  fmnb_pkg::req_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output fmnb_pkg::req_t rd_data
);
    fmnb_pkg::req_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/fmnb_back.sv -----
// ----------------------------------------------------------------------------
// fmnb_back
// cents, note choice with hysteresis, serial bend division and output register
// ----------------------------------------------------------------------------
module fmnb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  fmnb_pkg::req_t req,
    input  logic [11:0]    range,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [6:0]     note,
    output logic [13:0]    bend,
    output logic           note_changed,
    output logic           bend_changed
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NOTE = 3'd1;
    localparam logic [2:0] S_DEV  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic signed [39:0] c_reg, c_next;       // cents q.16
    logic signed [39:0] d_reg, d_next;
    logic [6:0]  note_reg, note_next;        // result note
    logic [6:0]  held_reg, held_next;
    logic        hv_reg, hv_next;
    logic [13:0] shown_reg, shown_next;
    logic [11:0] rng_reg, rng_next;
    logic [52:0] rem_reg, rem_next;          // |d|*8192 dividend / remainder
    logic [14:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        ov_reg, ov_next;
    logic [6:0]  onote_reg, onote_next;
    logic [13:0] obend_reg, obend_next;
    logic        onc_reg, onc_next, obc_reg, obc_next;

    logic signed [39:0] diff, d_held, d_new, mag;
    logic [39:0]        n_full;
    logic [6:0]         n_sel;
    logic [27:0]        div_sh;
    logic [53:0]        trial;
    logic signed [16:0] b_val;
    logic [13:0]        b_clamp;

    assign diff   = 40'(signed'({19'd0, req.lg})) - 40'(signed'({19'd0, fmnb_pkg::L440}));
    assign d_held = c_reg - 40'(held_reg) * 40'sd6553600;
    assign mag    = d_held[39] ? -d_held : d_held;
    // note = c / 6553600 via reciprocal of c >> 16, exact over the cents range
    assign n_full = 40'((c_reg >>> 16) * 40'd5243) >> 19;
    assign n_sel  = c_reg[39] ? 7'd0 :
                    (n_full > 40'd127) ? fmnb_pkg::NOTE_MAX : n_full[6:0];
    assign d_new  = c_reg - 40'(n_sel) * 40'sd6553600;
    assign div_sh = {rng_reg, 16'd0};
    assign trial  = {1'b0, rem_reg} - ({26'd0, div_sh} << cnt_reg);

    always_comb
    begin
        if (ov_reg)
        begin
            b_val = d_reg[39] ? 17'sd0 : 17'sd16383;
        end
        else if (d_reg[39])
        begin
            b_val = 17'sd8192 - 17'(signed'({1'b0, q_reg}));
        end
        else
        begin
            b_val = 17'sd8192 + 17'(signed'({1'b0, q_reg}));
        end
        if (b_val < 0)
        begin
            b_clamp = 14'd0;
        end
        else if (b_val > 17'sd16383)
        begin
            b_clamp = fmnb_pkg::BEND_MAX;
        end
        else
        begin
            b_clamp = b_val[13:0];
        end
    end

    assign req_ready    = (state_reg == S_IDLE) && !out_valid;
    assign note         = onote_reg;
    assign bend         = obend_reg;
    assign note_changed = onc_reg;
    assign bend_changed = obc_reg;

    logic out_set, out_clr;

    always_comb
    begin
        state_next = state_reg;
        c_next = c_reg; d_next = d_reg; note_next = note_reg;
        held_next = held_reg; hv_next = hv_reg; shown_next = shown_reg;
        rng_next = rng_reg; rem_next = rem_reg; q_next = q_reg;
        cnt_next = cnt_reg; ov_next = ov_reg;
        onote_next = onote_reg; obend_next = obend_reg;
        onc_next = onc_reg; obc_next = obc_reg;
        out_set = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    rng_next = (range == 12'd0) ? 12'd1 : range;
                    if (req.zero)
                    begin
                        onote_next = 7'd0;
                        obend_next = 14'd0;
                        onc_next   = (held_reg != 7'd0);
                        obc_next   = (shown_reg != 14'd0);
                        held_next  = 7'd0;
                        shown_next = 14'd0;
                        hv_next    = 1'b0;
                        out_set    = 1'b1;
                    end
                    else
                    begin
                        c_next     = diff * 40'sd1200 + 40'sd452198400;
                        state_next = S_NOTE;
                    end
                end
            end
            S_NOTE:
            begin
                if (hv_reg && (mag <= 40'(signed'({1'b0, rng_reg, 16'd0}))))
                begin
                    note_next = held_reg;
                    d_next    = d_held;
                    state_next = S_DEV;
                end
                else if (!c_reg[39] && !d_new[39] && d_new >= 40'sd6553600 &&
                         n_sel != fmnb_pkg::NOTE_MAX)
                begin
                    // reciprocal estimate was one low
                    c_next = c_reg;
                    note_next = n_sel + 7'd1;
                    d_next = d_new - 40'sd6553600;
                    state_next = S_DEV;
                end
                else
                begin
                    note_next = n_sel;
                    d_next    = d_new;
                    state_next = S_DEV;
                end
            end
            S_DEV:
            begin
                rem_next   = 53'(d_reg[39] ? -d_reg : d_reg) << 13;
                q_next     = '0;
                ov_next    = 1'b0;
                cnt_next   = 5'd14;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (!trial[53])
                begin
                    rem_next = trial[52:0];
                    q_next   = {q_reg[13:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[13:0], 1'b0};
                end
                if (cnt_reg == 5'd14 && !trial[53] &&
                    (rem_reg >= ({25'd0, div_sh} << 15)))
                begin
                    ov_next = 1'b1;
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                onote_next = note_reg;
                obend_next = b_clamp;
                onc_next   = (note_reg != held_reg);
                obc_next   = (b_clamp != shown_reg);
                held_next  = note_reg;
                shown_next = b_clamp;
                hv_next    = 1'b1;
                out_set    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_clr = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= 7'd0;
            hv_reg    <= 1'b0;
            shown_reg <= fmnb_pkg::BEND_CENTER;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            hv_reg    <= hv_next;
            shown_reg <= shown_next;
            if (out_set)
            begin
                out_valid <= 1'b1;
            end
            else if (out_clr)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next; d_reg <= d_next; note_reg <= note_next;
        rng_reg <= rng_next; rem_reg <= rem_next; q_reg <= q_next;
        cnt_reg <= cnt_next; ov_reg <= ov_next;
        onote_reg <= onote_next; obend_reg <= obend_next;
        onc_reg <= onc_next; obc_reg <= obc_next;
    end

endmodule

// ----- rtl/frequency_to_midi_note_bend.sv -----
// steps: 16 log2 squarings in the front, then note choice and 15 bend quotient
// bits in the back; a zero frequency skips the note choice and the division
// flow: the back takes a new request only when idle and its last result has
// been taken; the front takes a new frequency once its last log2 result is queued
// reset: asynchronous active low; range 100 cents, no note held, bend shown 8192
// ----------------------------------------------------------------------------
// frequency_to_midi_note_bend
// frequency to midi note and pitch bend with note hysteresis
// ----------------------------------------------------------------------------
module frequency_to_midi_note_bend #(
    parameter int FREQ_WIDTH = fmnb_pkg::FREQ_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FREQ_WIDTH-1:0] frequency,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [11:0]           cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [6:0]            note,
    output logic [13:0]           bend,
    output logic                  note_changed,
    output logic                  bend_changed
);
    logic [11:0]    range_reg;
    logic           f_valid, f_ready, b_valid, b_ready;
    fmnb_pkg::req_t f_req, b_req;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= fmnb_pkg::RANGE_RESET;
        end
        else if (cfg_valid)
        begin
            range_reg <= cfg_data;
        end
    end

    fmnb_front #(.FREQ_WIDTH(FREQ_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .freq(frequency), .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
    );

    fmnb_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_data(f_req), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_req)
    );

    fmnb_back u_back (
        .clk(clk), .rst_n(rst_n), .req_valid(b_valid), .req_ready(b_ready),
        .req(b_req), .range(range_reg), .out_valid(out_valid),
        .out_ready(out_ready), .note(note), .bend(bend),
        .note_changed(note_changed), .bend_changed(bend_changed)
    );

endmodule

// ----- rtl/fmnb_checker.sv -----
// ----------------------------------------------------------------------------
// fmnb_props
// port-level checks on the result channel
// ----------------------------------------------------------------------------
module fmnb_props (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [6:0]  note,
    input logic [13:0] bend
);
    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(note) && $stable(bend))
        else $error("result changed while stalled");

    // no result while reset is held
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result during reset");

    // results are spaced by the iterative work
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("back to back result");

endmodule

bind frequency_to_midi_note_bend fmnb_props u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .note(note), .bend(bend)
);

// ----- sim/fmnb_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fmnb_checker
// watches the frequency, config and result channels, predicts note and bend
// with its own fixed point pitch model and compares every result in order
// ----------------------------------------------------------------------------
module fmnb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [23:0] frequency,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [11:0] cfg_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [6:0]  note,
    input  logic [13:0] bend,
    input  logic        note_changed,
    input  logic        bend_changed,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [6:0]  note;
        logic [13:0] bend;
        logic        note_chg;
        logic        bend_chg;
    } pitch_result_t;

    pitch_result_t pitch_q[$];
    logic [11:0] range_cents;
    logic [6:0]  last_note;
    logic        note_held;
    logic [13:0] last_bend;

    function automatic longint log2_fix(input logic [31:0] x);
        int          msb;
        logic [63:0] m;
        logic [15:0] frac;
        msb = 0;
        frac = '0;
        for (int i = 0; i < 32; i++)
            if (x[i])
                msb = i;
        m = 64'(x) << (31 - msb);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            frac = {frac[14:0], 1'b0};
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (longint'(msb) << 16) | longint'(frac);
    endfunction

    function automatic pitch_result_t predict_pitch(input logic [23:0] f);
        pitch_result_t r;
        longint rng, cents, dev, mag, b;
        logic [6:0]  n;
        logic [13:0] bd;
        rng = (range_cents == 0) ? 1 : longint'(range_cents);
        if (f == 0)
        begin
            n = 0;
            bd = 0;
            note_held = 1'b0;
        end
        else
        begin
            cents = 1200 * (log2_fix({8'd0, f}) - log2_fix(32'd112640)) + 64'sd6900 * 65536;
            dev = cents - longint'(last_note) * 6553600;
            mag = dev < 0 ? -dev : dev;
            if (!(note_held && mag <= rng * 65536))
            begin
                if (cents < 0)
                    n = 0;
                else if (cents / 6553600 > 127)
                    n = 7'd127;
                else
                    n = 7'(cents / 6553600);
                dev = cents - longint'(n) * 6553600;
            end
            else
                n = last_note;
            b = 8192 + (dev * 8192) / (rng * 65536);
            if (b < 0)
                b = 0;
            if (b > 16383)
                b = 16383;
            bd = 14'(b);
            note_held = 1'b1;
        end
        r.note = n;
        r.bend = bd;
        r.note_chg = (n != last_note);
        r.bend_chg = (bd != last_bend);
        last_note = n;
        last_bend = bd;
        return r;
    endfunction

    assign pending = pitch_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        pitch_result_t exp_r;
        if (!rst_n)
        begin
            range_cents <= 12'd100;
            last_note = 0;
            note_held = 0;
            last_bend = 14'd8192;
            fail_count <= 0;
            pitch_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                range_cents <= cfg_data;
            if (in_valid && in_ready)
                pitch_q.push_back(predict_pitch(frequency));
            if (out_valid && out_ready)
            begin
                if (pitch_q.size() == 0)
                begin
                    $display("%0t: unexpected result note %0d bend %0d", $time, note, bend);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = pitch_q.pop_front();
                    if (exp_r != {note, bend, note_changed, bend_changed})
                    begin
                        $display("%0t: mismatch expected note %0d bend %0d nc %0d bc %0d, got note %0d bend %0d nc %0d bc %0d",
                                 $time, exp_r.note, exp_r.bend, exp_r.note_chg, exp_r.bend_chg,
                                 note, bend, note_changed, bend_changed);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- sim/tb_frequency_to_midi_note_bend.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frequency_to_midi_note_bend
// drives frequencies and range writes with random idling and back pressure,
// the checker predicts and compares every note and bend result
// ----------------------------------------------------------------------------
module tb_frequency_to_midi_note_bend;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [23:0] frequency;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  note;
    logic [13:0] bend;
    logic        note_changed;
    logic        bend_changed;
    int          fail_count;
    int          pending;
    int          cycle_count;
    bit          calm;
    bit          hold_sink;

    frequency_to_midi_note_bend #(.FREQ_WIDTH(24)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .frequency(frequency),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .note(note), .bend(bend), .note_changed(note_changed), .bend_changed(bend_changed)
    );

    fmnb_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .frequency(frequency),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .note(note), .bend(bend), .note_changed(note_changed), .bend_changed(bend_changed),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                out_ready <= 0;
                repeat (300) @(posedge clk);
                hold_sink = 0;
            end
            out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    // valid stays up across back to back requests
    task automatic send_freq(input logic [23:0] f);
        while (!calm && $urandom_range(99) < 24)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        frequency <= f;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_range(input logic [11:0] r);
        drain();
        cfg_valid <= 1;
        cfg_data <= r;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // mostly audible pitches with small drifts so the hysteresis path is hit
    function automatic logic [23:0] rand_freq();
        int k;
        k = $urandom_range(99);
        if (k < 5)
            return 24'd0;
        if (k < 15)
            return 24'($urandom);
        if (k < 25)
            return 24'(1 << $urandom_range(23)) | 24'($urandom_range(1));
        return 24'($urandom_range(20 * 256, 4000 * 256));
    endfunction

    initial
    begin
        logic [11:0] ranges [6];
        logic [23:0] base;
        ranges = '{12'd1, 12'd2400, 12'd0, 12'd50, 12'd4095, 12'd200};
        rst_n = 0;
        in_valid = 0;
        frequency = 0;
        cfg_valid = 0;
        cfg_data = 0;
        calm = 0;
        hold_sink = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, zero, reference pitch, small drifts around a note
        send_freq(24'd0);
        send_freq(24'd1);
        send_freq(24'hFFFFFF);
        send_freq(24'd112640);
        send_freq(24'd112700);
        send_freq(24'd113500);
        send_freq(24'd118000);
        send_freq(24'd0);
        send_freq(24'd112640);
        send_freq(24'd256);
        send_freq(24'h800000);
        send_freq(24'h555555);
        send_freq(24'hAAAAAA);
        send_freq(24'(2093 * 256));

        for (int ph = 0; ph < 6; ph++)
        begin
            write_range(ranges[ph]);
            calm = (ph == 2);
            if (ph == 1)
                hold_sink = 1;
            base = rand_freq();
            for (int i = 0; i < 115; i++)
            begin
                if ($urandom_range(2) == 0)
                    base = rand_freq();
                else
                    base = base + 24'($urandom_range(400)) - 24'd200;
                send_freq(base);
                if (ph == 3 && i == 50)
                    drain();
            end
        end
        calm = 0;
        drain();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
